### hw/rtl/phgc_pkg.sv
// Shared types and constants for the pulse height gain calibration block.
`default_nettype none

package phgc_pkg;

  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_LOAD  = 1'b1;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_DITHER_OFFSET = 3'd0,
    REG_DITHER_ENABLE = 3'd1,
    REG_COEF_COUNT    = 3'd2,
    REG_PHA_MIN       = 3'd3,
    REG_PHA_MAX       = 3'd4,
    REG_PI_MIN        = 3'd5,
    REG_PI_MAX        = 3'd6
  } cfg_reg_t;

  // Horner accumulator travelling down the chain
  typedef struct packed {
    logic        valid;
    logic        sat;
    logic [63:0] acc;
  } token_t;

  // Per-item selection shared by every cell
  typedef struct packed {
    logic       sel_b;
    logic [3:0] coef_count;
  } cell_ctl_t;

  // Coefficient load broadcast to the cells
  typedef struct packed {
    logic        valid;
    logic        set_b;
    logic [2:0]  index;
    logic [63:0] value;
  } load_t;

endpackage

`default_nettype wire

### hw/rtl/phgc_cell.sv
// One Horner cell: holds both sets' coefficient for its power, does acc*X/2^16 + c.
`default_nettype none

module phgc_cell #(
  parameter int CELL_INDEX = 0,
  parameter int XW         = 35
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire phgc_pkg::token_t       tok_in,
  output phgc_pkg::token_t            tok_out,
  input  wire logic signed [XW-1:0]   x,
  input  wire phgc_pkg::cell_ctl_t    ctl,
  input  wire phgc_pkg::load_t        load
);

  logic [63:0] coef_a;
  logic [63:0] coef_b;
  logic [63:0] coef;
  logic        enable;

  logic                  v1;
  logic                  sat1;
  logic [63:0]           acc1;
  logic signed [32+XW:0] p_lo;
  logic signed [31+XW:0] p_hi;

  logic [63+XW:0] full;
  logic [47+XW:0] shifted;
  logic [XW-16:0] top_bits;
  logic           fits;
  logic [63:0]    prod;
  logic [63:0]    sum;
  logic           add_ovf;
  logic [63:0]    result;
  logic           result_sat;

  logic        out_valid;
  logic        out_sat;
  logic [63:0] out_acc;

  always_ff @(posedge clk) begin
    if (load.valid && (32'(load.index) == CELL_INDEX)) begin
      if (load.set_b) begin
        coef_b <= load.value;
      end else begin
        coef_a <= load.value;
      end
    end
  end

  assign coef   = ctl.sel_b ? coef_b : coef_a;
  assign enable = 32'(ctl.coef_count) > CELL_INDEX;

  // Stage one: partial products of the accumulator halves
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    sat1 <= tok_in.sat;
    acc1 <= tok_in.acc;
    p_lo <= $signed({1'b0, tok_in.acc[31:0]}) * x;
    p_hi <= $signed(tok_in.acc[63:32]) * x;
  end

  // Stage two: combine, floor shift, saturate, add coefficient
  always_comb begin
    full     = {p_hi, 32'd0} + {{31{p_lo[32+XW]}}, p_lo};
    shifted  = full[63+XW:16];
    top_bits = shifted[47+XW:63];
    fits     = (&top_bits) || !(|top_bits);
    if (fits) begin
      prod = shifted[63:0];
    end else begin
      prod = shifted[47+XW] ? phgc_pkg::S64_MIN : phgc_pkg::S64_MAX;
    end
    sum     = prod + coef;
    add_ovf = (prod[63] == coef[63]) && (sum[63] != prod[63]);
    if (add_ovf) begin
      result = prod[63] ? phgc_pkg::S64_MIN : phgc_pkg::S64_MAX;
    end else begin
      result = sum;
    end
    result_sat = sat1 || !fits || add_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
  end

  // Cells at or above the coefficient count pass the accumulator through
  always_ff @(posedge clk) begin
    out_acc <= enable ? result : acc1;
    out_sat <= enable ? result_sat : sat1;
  end

  assign tok_out = '{valid: out_valid, sat: out_sat, acc: out_acc};

endmodule

`default_nettype wire

### hw/rtl/detector_pulse_height_gain_calibration_unit.sv
// Top level of the pulse height gain calibration block: front end, cell chain, result queue.
// An event passes the start register, then each two-stage cell in turn, then the result queue and
// the output register; no new item is taken while the chain is busy or the queue holds a result.
// Null events go straight to the result queue and then the output register; loads write the cells directly.
// Synchronous reset clears control and sets configuration to its defaults; coefficients hold until loaded.
`default_nettype none

module detector_pulse_height_gain_calibration_unit #(
  parameter int MAX_COEFFS  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   mode,
  input  wire logic [1:0]             unit_id,
  input  wire logic [SAMPLE_BITS-1:0] adc_peak,
  input  wire logic [SAMPLE_BITS-1:0] adc_pedestal,
  input  wire logic                   status_good,
  input  wire logic                   event_lost,
  input  wire logic [15:0]            dither,
  input  wire logic                   coef_set,
  input  wire logic [2:0]             coef_index,
  input  wire logic signed [63:0]     coef_value,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [16:0]          pha_out,
  output logic signed [31:0]          pi_out,
  output logic                        is_null,
  output logic                        pha_replaced,
  output logic                        pi_replaced,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [31:0]            cfg_data
);

  localparam int XW  = ((SAMPLE_BITS + 17 > 32) ? SAMPLE_BITS + 17 : 32) + 2;
  localparam int PHW = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;

  // Configuration registers
  logic signed [31:0] dither_offset;
  logic               dither_enable;
  logic [3:0]         coef_count;
  logic signed [16:0] pha_min;
  logic signed [16:0] pha_max;
  logic signed [31:0] pi_min;
  logic signed [31:0] pi_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dither_offset <= '0;
      dither_enable <= 1'b1;
      coef_count    <= 4'd1;
      pha_min       <= '0;
      pha_max       <= 17'sd65535;
      pi_min        <= '0;
      pi_max        <= 32'sd65535;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        phgc_pkg::REG_DITHER_OFFSET: dither_offset <= cfg_data;
        phgc_pkg::REG_DITHER_ENABLE: dither_enable <= cfg_data[0];
        phgc_pkg::REG_COEF_COUNT:    coef_count    <= cfg_data[3:0];
        phgc_pkg::REG_PHA_MIN:       pha_min       <= cfg_data[16:0];
        phgc_pkg::REG_PHA_MAX:       pha_max       <= cfg_data[16:0];
        phgc_pkg::REG_PI_MIN:        pi_min        <= cfg_data;
        phgc_pkg::REG_PI_MAX:        pi_max        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end
  logic                     in_acc;
  logic                     is_load;
  logic                     is_null_evt;
  logic                     is_calc;
  logic signed [SAMPLE_BITS:0] pha_next;
  logic signed [15:0]       dither_c;
  logic signed [XW-1:0]     x_next;

  logic                     busy;
  logic                     start_valid;
  logic                     sel_b;
  logic signed [XW-1:0]     x_reg;
  logic signed [SAMPLE_BITS:0] pha_reg;

  logic                     pend_valid;
  logic signed [16:0]       pend_pha;
  logic signed [31:0]       pend_pi;
  logic                     pend_null;
  logic                     pend_pha_rep;
  logic                     pend_pi_rep;

  phgc_pkg::token_t         tok [MAX_COEFFS+1];

  assign in_stall    = busy || pend_valid;
  assign in_acc      = in_valid && !in_stall;
  assign is_load     = mode == phgc_pkg::MODE_LOAD;
  assign is_null_evt = !is_load && (!status_good || event_lost);
  assign is_calc     = !is_load && status_good && !event_lost;

  always_comb begin
    pha_next = $signed({1'b0, adc_peak}) - $signed({1'b0, adc_pedestal});
    // dither minus one half, as a signed Q.16 fraction
    dither_c = $signed({~dither[15], dither[14:0]});
    x_next   = (XW'(pha_next) <<< 16) + XW'(dither_offset);
    if (dither_enable) begin
      x_next = x_next + XW'(dither_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      start_valid <= 1'b0;
    end else begin
      start_valid <= in_acc && is_calc;
      if (in_acc && is_calc) begin
        busy <= 1'b1;
      end else if (tok[0].valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_calc) begin
      x_reg   <= x_next;
      pha_reg <= pha_next;
      sel_b   <= unit_id[1];
    end
  end

  // Cell chain: the accumulator enters at the highest power and leaves at cell 0
  phgc_pkg::cell_ctl_t ctl;
  phgc_pkg::load_t     load;

  assign tok[MAX_COEFFS] = '{valid: start_valid, sat: 1'b0, acc: 64'd0};
  assign ctl  = '{sel_b: sel_b, coef_count: coef_count};
  assign load = '{valid: in_acc && is_load, set_b: coef_set, index: coef_index,
                  value: coef_value};

  for (genvar k = 0; k < MAX_COEFFS; k++) begin : g_cell
    phgc_cell #(
      .CELL_INDEX(k),
      .XW        (XW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[k+1]),
      .tok_out(tok[k]),
      .x      (x_reg),
      .ctl    (ctl),
      .load   (load)
    );
  end

  // Back end: channel value, range replacement
  logic signed [20:0] pi_raw;
  logic signed [31:0] pi_wide;
  logic signed [PHW-1:0] pha_w;
  logic               pha_rep;
  logic               pi_rep;

  always_comb begin
    pi_raw  = $signed(tok[0].acc[63:43]);
    pi_wide = 32'(pi_raw);
    pi_rep  = tok[0].sat || (pi_wide < pi_min) || (pi_wide > pi_max);
    pha_w   = PHW'(pha_reg);
    pha_rep = (pha_w < PHW'(pha_min)) || (pha_w > PHW'(pha_max));
  end

  logic move_out;
  assign move_out = pend_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if ((in_acc && is_null_evt) || tok[0].valid) begin
      pend_valid <= 1'b1;
    end else if (move_out) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_null_evt) begin
      pend_pha     <= '0;
      pend_pi      <= '0;
      pend_null    <= 1'b1;
      pend_pha_rep <= 1'b0;
      pend_pi_rep  <= 1'b0;
    end else if (tok[0].valid) begin
      pend_pha     <= pha_rep ? pha_max : 17'(pha_reg);
      pend_pi      <= pi_rep ? pi_max : pi_wide;
      pend_null    <= 1'b0;
      pend_pha_rep <= pha_rep;
      pend_pi_rep  <= pi_rep;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      pha_out      <= pend_pha;
      pi_out       <= pend_pi;
      is_null      <= pend_null;
      pha_replaced <= pend_pha_rep;
      pi_replaced  <= pend_pi_rep;
    end
  end

`ifndef NO_ASSERTIONS
  a_tok_when_busy: assert property (@(posedge clk) disable iff (rst)
    tok[0].valid |-> busy)
    else $error("chain result without an item in flight");

  a_pend_free: assert property (@(posedge clk) disable iff (rst)
    tok[0].valid |-> !pend_valid)
    else $error("chain result would overwrite a waiting result");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_calc) |=> (busy && start_valid))
    else $error("accepted event did not enter the chain");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && out_valid && out_stall) |=> pend_valid)
    else $error("waiting result dropped while output stalled");
`endif

endmodule

`default_nettype wire
